// ===== hdl/lir_pkg.sv =====
`default_nettype none
package lir_pkg;

  localparam int unsigned MaxItems = 16;
  localparam int unsigned IdxW     = 5;
  localparam int unsigned CntW     = 5;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned StatW    = 2;

  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [CmdW-1:0]  cmd_t;
  typedef logic [StatW-1:0] status_t;

  localparam cmd_t CmdBefore = 2'd0;
  localparam cmd_t CmdAfter  = 2'd1;
  localparam cmd_t CmdRead   = 2'd2;

  localparam status_t StOk    = 2'd0;
  localparam status_t StRange = 2'd1;
  localparam status_t StSame  = 2'd2;

  // table read address source
  typedef enum logic [1:0] {
    RD_ZERO   = 2'd0,
    RD_X      = 2'd1,
    RD_Y      = 2'd2,
    RD_CURSOR = 2'd3
  } rd_sel_e;

  // table write pattern
  typedef enum logic [1:0] {
    WR_NONE   = 2'd0,
    WR_UNLINK = 2'd1,
    WR_LINK_A = 2'd2,
    WR_LINK_B = 2'd3
  } wr_sel_e;

  typedef struct packed {
    logic    capture;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    logic    latch_x;
    logic    latch_y;
    logic    walk_start;
    logic    walk_beat;
    logic    report;
  } lir_ctrl_t;

  typedef struct packed {
    logic is_read;
    logic move_ok;
    logic walk_last;
    logic out_free;
  } lir_stat_t;

  function automatic idx_t ring_next(idx_t i, cnt_t cnt);
    idx_t r;
    if (i == cnt) begin
      r = '0;
    end else if (i < cnt) begin
      r = i + idx_t'(1);
    end else begin
      r = '0;
    end
    return r;
  endfunction

  function automatic idx_t ring_prev(idx_t i, cnt_t cnt);
    idx_t r;
    if (i == '0) begin
      r = idx_t'(cnt);
    end else if (i <= cnt) begin
      r = i - idx_t'(1);
    end else begin
      r = '0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/lir_ifs.sv =====
`default_nettype none
interface lir_in_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           command;
  logic [4:0]           item_x;
  logic [4:0]           item_y;

  modport source (output valid, command, item_x, item_y, input ready);
  modport sink   (input valid, command, item_x, item_y, output ready);
endinterface

interface lir_out_if;
  logic                 valid;
  logic                 ready;
  logic [4:0]           item;
  logic                 last;
  logic [1:0]           status;

  modport source (output valid, item, last, status, input ready);
  modport sink   (input valid, item, last, status, output ready);
endinterface
`default_nettype wire

// ===== hdl/list_item_relocate_unit.sv =====
`default_nettype none
// Keeps an ordering of items 1..item_count as a doubly linked ring with a
// sentinel entry, and moves items within it or reads it out.
// in_ch: one beat per command (0 move X before Y, 1 move X after Y, 2 read).
// out_ch: a move gives one beat (item 0, last 1, status); a readout gives
//   item_count beats in list order, status 0, last on the final one.
// cfg_we_i/cfg_data_i: writes item_count (clamped to 1..16) and rebuilds the
//   order 1..item_count in the same cycle.
// Sequencing: a move walks decode, fetch X, unlink, fetch Y and two link
//   writes through the single read port and write port of each link table,
//   then reports its result; the block is idle again once it is loaded.
//   A rejected move goes from decode straight to the report. A readout
//   follows one link per cycle while the output register is free, and
//   gives one beat per link.
// One command is in flight at a time; in_ch.ready is high only when idle.
// The result sits in an output register; a stalled receiver holds the walk
//   or report until the register frees up.
// Reset: item_count 16, order 1..16, no result pending.
module list_item_relocate_unit (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_we_i,
  input  wire logic [4:0] cfg_data_i,
  lir_in_if.sink        in_ch,
  lir_out_if.source     out_ch
);

  lir_pkg::lir_ctrl_t ctrl;
  lir_pkg::lir_stat_t stat;

  lir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  lir_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .command_i    (in_ch.command),
    .item_x_i     (in_ch.item_x),
    .item_y_i     (in_ch.item_y),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .out_ready_i  (out_ch.ready),
    .out_valid_o  (out_ch.valid),
    .out_item_o   (out_ch.item),
    .out_last_o   (out_ch.last),
    .out_status_o (out_ch.status)
  );

endmodule
`default_nettype wire

// ===== hdl/lir_datapath.sv =====
`default_nettype none
module lir_datapath (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [4:0]            cfg_data_i,
  input  wire logic [1:0]            command_i,
  input  wire logic [4:0]            item_x_i,
  input  wire logic [4:0]            item_y_i,
  input  wire lir_pkg::lir_ctrl_t    ctrl_i,
  output lir_pkg::lir_stat_t         stat_o,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic [4:0]                 out_item_o,
  output logic                       out_last_o,
  output logic [1:0]                 out_status_o
);

  lir_pkg::idx_t    next_q [lir_pkg::MaxItems+1];
  lir_pkg::idx_t    prev_q [lir_pkg::MaxItems+1];
  lir_pkg::cnt_t    count_q;
  lir_pkg::cmd_t    cmd_q;
  lir_pkg::idx_t    x_q, y_q;
  lir_pkg::idx_t    pn_q, nn_q;     // neighbors of X before unlink
  lir_pkg::idx_t    p2_q, n2_q;     // insertion point
  lir_pkg::idx_t    cursor_q;
  lir_pkg::cnt_t    k_q;
  logic             out_valid_q;
  lir_pkg::idx_t    out_item_q;
  logic             out_last_q;
  lir_pkg::status_t out_status_q;

  lir_pkg::idx_t    rd_addr, next_rd, prev_rd;
  lir_pkg::idx_t    next_wa, next_wd, prev_wa, prev_wd;
  logic             wr_en;
  lir_pkg::cnt_t    cfg_cnt;
  logic             is_move, range_bad, out_load;
  lir_pkg::status_t res_status;

  always_comb begin
    unique case (ctrl_i.rd_sel)
      lir_pkg::RD_ZERO:   rd_addr = '0;
      lir_pkg::RD_X:      rd_addr = x_q;
      lir_pkg::RD_Y:      rd_addr = y_q;
      lir_pkg::RD_CURSOR: rd_addr = cursor_q;
      default:            rd_addr = '0;
    endcase
  end

  assign next_rd = next_q[rd_addr];
  assign prev_rd = prev_q[rd_addr];

  always_comb begin
    wr_en   = 1'b1;
    next_wa = pn_q;
    next_wd = nn_q;
    prev_wa = nn_q;
    prev_wd = pn_q;
    unique case (ctrl_i.wr_sel)
      lir_pkg::WR_NONE: begin
        wr_en = 1'b0;
      end
      lir_pkg::WR_UNLINK: begin
        next_wa = pn_q;
        next_wd = nn_q;
        prev_wa = nn_q;
        prev_wd = pn_q;
      end
      lir_pkg::WR_LINK_A: begin
        next_wa = p2_q;
        next_wd = x_q;
        prev_wa = n2_q;
        prev_wd = x_q;
      end
      lir_pkg::WR_LINK_B: begin
        next_wa = x_q;
        next_wd = n2_q;
        prev_wa = x_q;
        prev_wd = p2_q;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // written count is clamped to 1..MaxItems
  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_cnt = lir_pkg::cnt_t'(1);
    end else if (cfg_data_i > lir_pkg::cnt_t'(lir_pkg::MaxItems)) begin
      cfg_cnt = lir_pkg::cnt_t'(lir_pkg::MaxItems);
    end else begin
      cfg_cnt = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= lir_pkg::cnt_t'(lir_pkg::MaxItems);
      for (int i = 0; i <= lir_pkg::MaxItems; i++) begin
        next_q[i] <= lir_pkg::ring_next(lir_pkg::idx_t'(i), lir_pkg::cnt_t'(lir_pkg::MaxItems));
        prev_q[i] <= lir_pkg::ring_prev(lir_pkg::idx_t'(i), lir_pkg::cnt_t'(lir_pkg::MaxItems));
      end
    end else if (cfg_we_i) begin
      count_q <= cfg_cnt;
      for (int i = 0; i <= lir_pkg::MaxItems; i++) begin
        next_q[i] <= lir_pkg::ring_next(lir_pkg::idx_t'(i), cfg_cnt);
        prev_q[i] <= lir_pkg::ring_prev(lir_pkg::idx_t'(i), cfg_cnt);
      end
    end else if (wr_en) begin
      next_q[next_wa] <= next_wd;
      prev_q[prev_wa] <= prev_wd;
    end
  end

  assign is_move   = (cmd_q == lir_pkg::CmdBefore) || (cmd_q == lir_pkg::CmdAfter);
  assign range_bad = (x_q == '0) || (x_q > count_q) || (y_q == '0) || (y_q > count_q);

  // range check wins over X equals Y; unused command reports out of range
  always_comb begin
    if (!is_move || range_bad) begin
      res_status = lir_pkg::StRange;
    end else if (x_q == y_q) begin
      res_status = lir_pkg::StSame;
    end else begin
      res_status = lir_pkg::StOk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q <= command_i;
      x_q   <= item_x_i;
      y_q   <= item_y_i;
    end
    if (ctrl_i.latch_x) begin
      pn_q <= prev_rd;
      nn_q <= next_rd;
    end
    if (ctrl_i.latch_y) begin
      if (cmd_q == lir_pkg::CmdBefore) begin
        p2_q <= prev_rd;
        n2_q <= y_q;
      end else begin
        p2_q <= y_q;
        n2_q <= next_rd;
      end
    end
    if (ctrl_i.walk_start) begin
      cursor_q <= next_rd;
      k_q      <= '0;
    end else if (ctrl_i.walk_beat) begin
      cursor_q <= next_rd;
      k_q      <= k_q + lir_pkg::cnt_t'(1);
    end
    if (ctrl_i.walk_beat) begin
      out_item_q   <= cursor_q;
      out_last_q   <= stat_o.walk_last;
      out_status_q <= lir_pkg::StOk;
    end else if (ctrl_i.report) begin
      out_item_q   <= '0;
      out_last_q   <= 1'b1;
      out_status_q <= res_status;
    end
  end

  assign out_load = ctrl_i.walk_beat || ctrl_i.report;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.is_read   = (cmd_q == lir_pkg::CmdRead);
  assign stat_o.move_ok   = is_move && (res_status == lir_pkg::StOk);
  assign stat_o.walk_last = (k_q == (count_q - lir_pkg::cnt_t'(1)));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_item_o   = out_item_q;
  assign out_last_o   = out_last_q;
  assign out_status_o = out_status_q;

endmodule
`default_nettype wire

// ===== hdl/lir_ctrl.sv =====
`default_nettype none
module lir_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire lir_pkg::lir_stat_t stat_i,
  output lir_pkg::lir_ctrl_t      ctrl_o
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_DECODE  = 9'b000000010,
    S_FETCH_X = 9'b000000100,
    S_UNLINK  = 9'b000001000,
    S_FETCH_Y = 9'b000010000,
    S_LINK_A  = 9'b000100000,
    S_LINK_B  = 9'b001000000,
    S_REPORT  = 9'b010000000,
    S_WALK    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d           = state_q;
    ctrl_o            = '0;
    ctrl_o.rd_sel     = lir_pkg::RD_ZERO;
    ctrl_o.wr_sel     = lir_pkg::WR_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        ctrl_o.rd_sel = lir_pkg::RD_ZERO;
        if (stat_i.is_read) begin
          ctrl_o.walk_start = 1'b1;
          state_d           = S_WALK;
        end else if (stat_i.move_ok) begin
          state_d = S_FETCH_X;
        end else begin
          state_d = S_REPORT;
        end
      end
      S_FETCH_X: begin
        ctrl_o.rd_sel  = lir_pkg::RD_X;
        ctrl_o.latch_x = 1'b1;
        state_d        = S_UNLINK;
      end
      S_UNLINK: begin
        ctrl_o.wr_sel = lir_pkg::WR_UNLINK;
        state_d       = S_FETCH_Y;
      end
      S_FETCH_Y: begin
        // read Y's neighbor after the unlink has landed
        ctrl_o.rd_sel  = lir_pkg::RD_Y;
        ctrl_o.latch_y = 1'b1;
        state_d        = S_LINK_A;
      end
      S_LINK_A: begin
        ctrl_o.wr_sel = lir_pkg::WR_LINK_A;
        state_d       = S_LINK_B;
      end
      S_LINK_B: begin
        ctrl_o.wr_sel = lir_pkg::WR_LINK_B;
        state_d       = S_REPORT;
      end
      S_REPORT: begin
        if (stat_i.out_free) begin
          ctrl_o.report = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_WALK: begin
        ctrl_o.rd_sel = lir_pkg::RD_CURSOR;
        if (stat_i.out_free) begin
          ctrl_o.walk_beat = 1'b1;
          if (stat_i.walk_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule
`default_nettype wire

// ===== hdl/lir_checker.sv =====
`default_nettype none
module lir_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [4:0] out_item_i,
  input wire logic       out_last_i,
  input wire logic [1:0] out_status_i
);

  // one command at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken while a command is in flight");

  // mid-readout the block must not take a new command
  a_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_last_i) |-> !in_ready_i)
    else $error("input ready during a readout");

  // error status only on single report beats
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_status_i != lir_pkg::StOk)) |-> (out_last_i && (out_item_i == '0)))
    else $error("error status on a non-move beat");

  // nonzero items on OK beats lie within 1..MaxItems
  a_item_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_status_i == lir_pkg::StOk) && (out_item_i != '0))
      |-> (out_item_i <= 5'(lir_pkg::MaxItems)))
    else $error("readout item out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_item_i) && $stable(out_last_i) && $stable(out_status_i)))
    else $error("stalled result beat changed");

endmodule

bind list_item_relocate_unit lir_checker u_lir_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_ch.valid),
  .in_ready_i   (in_ch.ready),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .out_item_i   (out_ch.item),
  .out_last_i   (out_ch.last),
  .out_status_i (out_ch.status)
);
`default_nettype wire
